@@ sv/bbps_pkg.sv @@
// Shared constants for the buzzer beep pattern sequencer.
`timescale 1ns / 1ps

package bbps_pkg;

  localparam int unsigned PERIOD_BITS_DEF = 16;
  localparam int unsigned COUNT_BITS_DEF  = 16;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned FIELD_W  = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

endpackage

@@ sv/buzzer_beep_pattern_sequencer.sv @@
// The result word for an item is registered and shown in the cycle after the item is accepted.
// Throughput: one item per cycle unless held; each needs only compares and decrements.
// The input is held only while the single output register holds a word that is not taken.
// Reset (rst_n low, synchronous) clears all counters and reload values, drops the pin
// and empties the output register.
`timescale 1ns / 1ps

module buzzer_beep_pattern_sequencer
  import bbps_pkg::*;
#(
  parameter int unsigned PERIOD_BITS = PERIOD_BITS_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [FIELD_W-1:0] in_on_ticks,
  input  logic [FIELD_W-1:0] in_off_ticks,
  input  logic [FIELD_W-1:0] in_repeat_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_buzzer_on,
  output logic               out_pattern_active
);

  localparam logic [31:0] PERIOD_MAX = 32'((64'd1 << PERIOD_BITS) - 64'd1);
  localparam logic [31:0] COUNT_MAX  = 32'((64'd1 << COUNT_BITS) - 64'd1);
  localparam logic [PERIOD_BITS-1:0] P_ONE = PERIOD_BITS'(1);
  localparam logic [COUNT_BITS-1:0]  C_ONE = COUNT_BITS'(1);

  logic [PERIOD_BITS-1:0] on_reload_r, on_reload_nxt;
  logic [PERIOD_BITS-1:0] on_left_r, on_left_nxt;
  logic [PERIOD_BITS-1:0] off_reload_r, off_reload_nxt;
  logic [PERIOD_BITS-1:0] off_left_r, off_left_nxt;
  logic [COUNT_BITS-1:0]  beeps_left_r, beeps_left_nxt;
  logic                   pin_r, pin_nxt;

  logic out_valid_r, out_valid_nxt;
  logic buzzer_r, buzzer_nxt;
  logic active_r, active_nxt;

  logic [31:0] on_ext, off_ext, cnt_ext;
  logic [PERIOD_BITS-1:0] on_sat, off_sat;
  logic [COUNT_BITS-1:0]  cnt_sat;
  logic [PERIOD_BITS-1:0] on_work;
  logic                   accept;
  action_t                action;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;
  assign action   = action_t'(in_action);

  // Start values wider than the counters saturate to the counter maximum.
  assign on_ext  = {16'd0, in_on_ticks};
  assign off_ext = {16'd0, in_off_ticks};
  assign cnt_ext = {16'd0, in_repeat_count};
  assign on_sat  = (on_ext > PERIOD_MAX) ? PERIOD_MAX[PERIOD_BITS-1:0]
                                         : on_ext[PERIOD_BITS-1:0];
  assign off_sat = (off_ext > PERIOD_MAX) ? PERIOD_MAX[PERIOD_BITS-1:0]
                                          : off_ext[PERIOD_BITS-1:0];
  assign cnt_sat = (cnt_ext > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0]
                                         : cnt_ext[COUNT_BITS-1:0];

  always_comb begin
    on_reload_nxt  = on_reload_r;
    on_left_nxt    = on_left_r;
    off_reload_nxt = off_reload_r;
    off_left_nxt   = off_left_r;
    beeps_left_nxt = beeps_left_r;
    pin_nxt        = pin_r;
    on_work        = on_left_r;

    case (action)
      ACT_TICK: begin
        if (off_left_r > P_ONE) begin
          off_left_nxt = off_left_r - P_ONE;
        end else begin
          // The last gap tick restarts sounding and also counts the on phase.
          if (off_left_r == P_ONE) begin
            pin_nxt      = 1'b1;
            off_left_nxt = '0;
            on_work      = on_reload_r;
          end
          if (on_work == P_ONE) begin
            on_left_nxt = '0;
            pin_nxt     = 1'b0;
            if (beeps_left_r == C_ONE) begin
              beeps_left_nxt = '0;
            end else if (beeps_left_r > C_ONE) begin
              beeps_left_nxt = beeps_left_r - C_ONE;
              off_left_nxt   = off_reload_r;
            end
          end else if (on_work > P_ONE) begin
            on_left_nxt = on_work - P_ONE;
          end else begin
            on_left_nxt = on_work;
          end
        end
      end
      ACT_START: begin
        if (on_left_r == '0 && in_on_ticks != '0 && in_off_ticks != '0
            && in_repeat_count != '0) begin
          on_reload_nxt  = on_sat;
          on_left_nxt    = on_sat;
          off_reload_nxt = off_sat;
          off_left_nxt   = '0;
          beeps_left_nxt = cnt_sat;
          pin_nxt        = 1'b1;
        end
      end
      ACT_STOP: begin
        if (on_left_r != '0 || off_left_r != '0 || beeps_left_r != '0) begin
          on_left_nxt    = '0;
          off_left_nxt   = '0;
          beeps_left_nxt = '0;
          pin_nxt        = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    buzzer_nxt    = buzzer_r;
    active_nxt    = active_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      buzzer_nxt    = pin_nxt;
      active_nxt    = (on_left_nxt != '0) || (off_left_nxt != '0)
                      || (beeps_left_nxt != '0);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_reload_r  <= '0;
      on_left_r    <= '0;
      off_reload_r <= '0;
      off_left_r   <= '0;
      beeps_left_r <= '0;
      pin_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        on_reload_r  <= on_reload_nxt;
        on_left_r    <= on_left_nxt;
        off_reload_r <= off_reload_nxt;
        off_left_r   <= off_left_nxt;
        beeps_left_r <= beeps_left_nxt;
        pin_r        <= pin_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result word payload needs no reset.
  always_ff @(posedge clk) begin
    buzzer_r <= buzzer_nxt;
    active_r <= active_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_buzzer_on      = buzzer_r;
  assign out_pattern_active = active_r;

endmodule
